// ----- rtl/core/ipws_pkg.sv -----
// Shared types and constants for the interval profiler core.
// Used by every module of rtl/core except ipws_checker; depends on nothing.
`default_nettype none
package ipws_pkg;

  localparam int MaxIntervals = 64;
  localparam int IdxW         = $clog2(MaxIntervals);
  localparam int CntW         = 7;
  localparam int TsW          = 32;
  localparam int Q8W          = 40;
  localparam int OutW         = 160;
  localparam int CfgIdxW      = 1;
  localparam int CfgDataW     = 7;
  localparam int AccW         = 86;
  localparam int VarW         = 80;
  localparam int SqRemW       = 43;
  localparam int SqSteps      = 40;
  localparam int DivSteps     = AccW;

  localparam logic [CfgIdxW-1:0] RegCapacity  = 1'd0;
  localparam logic [CfgIdxW-1:0] RegStatsMode = 1'd1;

  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpStop  = 2'd1;
  localparam logic [1:0] OpCalc  = 2'd2;

  localparam logic [1:0] ModeAuto1 = 2'd1;
  localparam logic [1:0] ModeAuto2 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_RUNNING = 3'd1,
    ST_STOPPED = 3'd2,
    ST_FULL    = 3'd3,
    ST_ERROR   = 3'd4
  } run_status_t;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_STOP,
    CMD_CALC,
    CMD_NOP
  } cmd_t;

  typedef struct packed {
    cmd_t            cmd;
    logic [TsW-1:0]  ts;
  } cmd_word_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_CALC,
    B_P1_RD,
    B_P1_ACC,
    B_DIV,
    B_P2_RD,
    B_P2_DIFF,
    B_P2_MUL,
    B_SQRT,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/core/ipws_front.sv -----
// Input side: accepts words, decodes the operation and queues them.
// Depends on ipws_pkg.
`default_nettype none
module ipws_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      s_tvalid,
  output logic                     s_tready,
  input  wire  [ipws_pkg::TsW-1:0] s_tdata,   // timestamp
  input  wire  [1:0]               s_tuser,   // op
  output logic                     q_valid,
  input  wire                      q_ready,
  output ipws_pkg::cmd_word_t      q_word
);
  import ipws_pkg::*;

  cmd_word_t  slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cmd_dec;
  logic       push;
  logic       pop;

  always_comb begin
    unique case (s_tuser)
      OpStart: cmd_dec = CMD_START;
      OpStop:  cmd_dec = CMD_STOP;
      OpCalc:  cmd_dec = CMD_CALC;
      default: cmd_dec = CMD_NOP;
    endcase
  end

  assign s_tready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_word   = slot[rd_ptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{cmd: cmd_dec, ts: s_tdata};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ipws_back.sv -----
// Execution side: profiler state, interval memory, statistics engine
// and the result register. Depends on ipws_pkg.
`default_nettype none
module ipws_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_valid,
  input  wire  [ipws_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [ipws_pkg::CfgDataW-1:0] cfg_data,
  input  wire                           q_valid,
  output logic                          q_ready,
  input  ipws_pkg::cmd_word_t           q_word,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  output logic [ipws_pkg::OutW-1:0]     m_tdata
);
  import ipws_pkg::*;

  logic [TsW-1:0]  mem [MaxIntervals];
  logic [TsW-1:0]  rd_data;

  logic [CntW-1:0] capacity;
  logic [1:0]      stats_mode;
  logic [TsW-1:0]  start_time;
  logic [CntW-1:0] stored_count;
  run_status_t     status;
  logic [TsW-1:0]  min_seen;
  logic [TsW-1:0]  max_seen;
  logic [Q8W-1:0]  mean_value;
  logic [Q8W-1:0]  dev_value;

  back_state_t     state;
  back_state_t     state_next;

  logic [CntW-1:0] ncalc;
  logic [CntW-1:0] idx;
  logic [TsW-1:0]  sum;
  logic [AccW-1:0] dvd;
  logic [CntW-1:0] div_rem;
  logic [CntW-1:0] iter;
  logic            div_var;
  logic [Q8W-1:0]  diff;
  logic [2:0]      kbyte;
  logic [2:0]      kcnt;
  logic [AccW-1:0] acc;
  logic [VarW-1:0] sq_v;
  logic [Q8W-1:0]  root;
  logic [SqRemW-1:0] sq_rem;

  logic [CntW-1:0] cap_eff;
  logic [CntW-1:0] n_eff;
  logic            has_room;
  logic            fills;
  logic            auto_mode;
  logic [TsW-1:0]  sum_new;
  logic            last_elem;
  logic [CntW:0]   div_t;
  logic            div_ge;
  logic [AccW-1:0] dvd_new;
  logic            div_done;
  logic [Q8W-1:0]  xs;
  logic [47:0]     pprod;
  logic [AccW-1:0] pprod_sh;
  logic [SqRemW-1:0] sq_t;
  logic [SqRemW-1:0] sq_trial;
  logic            sq_ge;
  logic [Q8W-1:0]  root_new;
  logic            out_free;

  always_comb begin
    cap_eff   = (capacity > CntW'(MaxIntervals)) ? CntW'(MaxIntervals) : capacity;
    n_eff     = (stored_count < cap_eff) ? stored_count : cap_eff;
    has_room  = stored_count < cap_eff;
    fills     = (stored_count + 1'b1) == cap_eff;
    auto_mode = (stats_mode == ModeAuto1) || (stats_mode == ModeAuto2);
    sum_new   = sum + rd_data;
    last_elem = (idx + 1'b1) == ncalc;
    div_t     = {div_rem, dvd[AccW-1]};
    div_ge    = div_t >= {1'b0, ncalc};
    dvd_new   = {dvd[AccW-2:0], div_ge};
    div_done  = iter == CntW'(DivSteps - 1);
    xs        = {rd_data, 8'd0};
    pprod     = diff * diff[8*kbyte +: 8];
    pprod_sh  = AccW'(pprod) << (8 * kbyte);
    sq_t      = {sq_rem[SqRemW-3:0], sq_v[VarW-1:VarW-2]};
    sq_trial  = {1'b0, root, 2'b01};
    sq_ge     = sq_t >= sq_trial;
    root_new  = {root[Q8W-2:0], sq_ge};
    out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    q_ready    = (state == B_IDLE);
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          unique case (q_word.cmd)
            CMD_STOP:  state_next = (has_room && fills && auto_mode) ? B_CALC : B_OUT;
            CMD_CALC:  state_next = (status == ST_STOPPED || status == ST_FULL) ?
                                    B_CALC : B_OUT;
            default:   state_next = B_OUT;
          endcase
        end
      end
      B_CALC:    state_next = (n_eff == '0) ? B_OUT : B_P1_RD;
      B_P1_RD:   state_next = B_P1_ACC;
      B_P1_ACC:  state_next = last_elem ? B_DIV : B_P1_RD;
      B_DIV:     state_next = div_done ? (div_var ? B_SQRT : B_P2_RD) : B_DIV;
      B_P2_RD:   state_next = B_P2_DIFF;
      B_P2_DIFF: state_next = B_P2_MUL;
      B_P2_MUL:  state_next = (kcnt == 3'd4) ? (last_elem ? B_DIV : B_P2_RD) : B_P2_MUL;
      B_SQRT:    state_next = (iter == CntW'(SqSteps - 1)) ? B_OUT : B_SQRT;
      B_OUT:     state_next = out_free ? B_IDLE : B_OUT;
      default:   state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && q_valid && q_word.cmd == CMD_STOP && has_room) begin
      mem[stored_count[IdxW-1:0]] <= q_word.ts - start_time;
    end
    rd_data <= mem[idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_CALC: begin
        ncalc <= n_eff;
        idx   <= '0;
        sum   <= '0;
      end
      B_P1_ACC: begin
        sum <= sum_new;
        idx <= idx + 1'b1;
        if (last_elem) begin
          dvd     <= {{(AccW - TsW - 8){1'b0}}, sum_new, 8'd0};
          div_rem <= '0;
          iter    <= '0;
          div_var <= 1'b0;
        end
      end
      B_DIV: begin
        div_rem <= div_ge ? CntW'(div_t - {1'b0, ncalc}) : div_t[CntW-1:0];
        dvd     <= dvd_new;
        iter    <= iter + 1'b1;
        if (div_done) begin
          idx    <= '0;
          acc    <= '0;
          iter   <= '0;
          sq_v   <= dvd_new[VarW-1:0];
          sq_rem <= '0;
          root   <= '0;
        end
      end
      B_P2_DIFF: begin
        diff  <= (xs >= mean_value) ? xs - mean_value : mean_value - xs;
        kbyte <= 3'd0;
        kcnt  <= 3'd0;
      end
      B_P2_MUL: begin
        acc   <= acc + pprod_sh;
        kbyte <= kbyte + 1'b1;
        kcnt  <= kcnt + 1'b1;
        if (kcnt == 3'd4) begin
          idx <= idx + 1'b1;
          if (last_elem) begin
            dvd     <= acc + pprod_sh;
            div_rem <= '0;
            iter    <= '0;
            div_var <= 1'b1;
          end
        end
      end
      B_SQRT: begin
        sq_rem <= sq_ge ? sq_t - sq_trial : sq_t;
        sq_v   <= {sq_v[VarW-3:0], 2'b00};
        root   <= root_new;
        iter   <= iter + 1'b1;
      end
      default: begin
      end
    endcase
    if (state == B_OUT && out_free) begin
      m_tdata <= {6'd0, dev_value, mean_value, max_seen, min_seen, stored_count, status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity     <= CntW'(MaxIntervals);
      stats_mode   <= 2'd0;
      start_time   <= '0;
      stored_count <= '0;
      status       <= ST_IDLE;
      min_seen     <= '1;
      max_seen     <= '0;
      mean_value   <= '0;
      dev_value    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == RegCapacity)  capacity   <= cfg_data;
        if (cfg_index == RegStatsMode) stats_mode <= cfg_data[1:0];
      end
      if (state == B_IDLE && q_valid) begin
        unique case (q_word.cmd)
          CMD_START: begin
            if (has_room) begin
              start_time <= q_word.ts;
              status     <= ST_RUNNING;
            end else begin
              status <= ST_FULL;
            end
          end
          CMD_STOP: begin
            if (has_room) begin
              stored_count <= stored_count + 1'b1;
              status       <= fills ? ST_FULL : ST_STOPPED;
            end else begin
              status <= ST_FULL;
            end
          end
          CMD_CALC: begin
            if (!(status == ST_STOPPED || status == ST_FULL)) status <= ST_ERROR;
          end
          default: begin
          end
        endcase
      end
      if (state == B_P1_ACC) begin
        if (rd_data < min_seen) min_seen <= rd_data;
        if (rd_data > max_seen) max_seen <= rd_data;
      end
      if (state == B_DIV && div_done && !div_var) mean_value <= dvd_new[Q8W-1:0];
      if (state == B_SQRT && iter == CntW'(SqSteps - 1)) dev_value <= root_new;
      if (state == B_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)              m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/interval_profiler_with_statistics_core.sv -----
// Top level of the interval profiler: input queue plus execution engine.
// Depends on ipws_pkg, ipws_front and ipws_back.
//
// Usage: each input word carries an op in s_tuser (start, stop, calculate)
// and a 32-bit timestamp in s_tdata. Every accepted word yields exactly one
// result word on the master side holding status, count, min, max, mean and
// standard deviation (8 fraction bits). The user must write registers on
// the cfg channel (index 0 capacity, index 1 statistics mode) only while
// the core is idle; the core itself does not enforce this. A two-word queue
// sits in front of the engine, so input is taken while the engine works or
// while a result waits in the output register. Start, ignored ops and stops
// that start no calculation pass from the queue through the output state
// into the output register. A calculation walks memory twice and divides
// twice, using the bit-serial divider, the byte-serial squarer and the
// two-bit-per-cycle square root. One item is processed at a time.
// Reset is synchronous: state returns to idle, count to zero, min to all
// ones, capacity to 64, the rest to zero; memory contents are not cleared.
// When the receiver stalls, the result holds in the output register, the
// engine waits, and the input queue fills and then drops s_tready.
`default_nettype none
module interval_profiler_with_statistics_core (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  input  wire  [ipws_pkg::TsW-1:0]      s_tdata,   // timestamp
  input  wire  [1:0]                    s_tuser,   // op
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // status[2:0], count[9:3], min_time[41:10], max_time[73:42],
  // mean_q8[113:74], stddev_q8[153:114], zero fill above
  output logic [ipws_pkg::OutW-1:0]     m_tdata,
  input  wire                           cfg_valid,
  output logic                          cfg_ready,
  input  wire  [ipws_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [ipws_pkg::CfgDataW-1:0] cfg_data
);
  import ipws_pkg::*;

  logic      q_valid;
  logic      q_ready;
  cmd_word_t q_word;

  assign cfg_ready = 1'b1;

  ipws_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_word   (q_word)
  );

  ipws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_word    (q_word),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule
`default_nettype wire

// ----- rtl/core/ipws_checker.sv -----
// Port-level checks for the interval profiler core, bound to the top level.
// Depends on interval_profiler_with_statistics_core.
`default_nettype none
module ipws_checker (
  input wire         clk,
  input wire         rst,
  input wire         m_tvalid,
  input wire         m_tready,
  input wire [159:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result word changed while stalled.");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result valid right after reset.");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= 3'd4)
    else $error("Status code out of range.");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[9:3] <= 7'd64)
    else $error("Stored count beyond memory depth.");

  a_minmax: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[73:42] != 32'd0 |-> m_tdata[41:10] <= m_tdata[73:42])
    else $error("Minimum exceeds maximum.");

endmodule

bind interval_profiler_with_statistics_core ipws_checker u_ipws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for interval_profiler_with_statistics_core.
// Drives start, stop and calculate words with random gaps and stalls and checks
// every result word against an in-bench profile predictor; depends on ipws_pkg.
`timescale 1ns / 1ps
module testbench;
  import ipws_pkg::*;

  typedef struct {
    run_status_t      status;
    logic [CntW-1:0]  count;
    logic [TsW-1:0]   min_time;
    logic [TsW-1:0]   max_time;
    logic [Q8W-1:0]   mean_q8;
    logic [Q8W-1:0]   stddev_q8;
  } profile_t;

  localparam logic [1:0] OpIgnored = 2'(CMD_NOP);
  localparam int StallLimit = 20000;
  localparam int CapW = CfgDataW;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [TsW-1:0]      s_tdata = '0;
  logic [1:0]          s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutW-1:0]     m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [CfgDataW-1:0] capacity_reg;
  logic [1:0]          mode_reg;
  logic [TsW-1:0]      intervals [MaxIntervals];
  logic [TsW-1:0]      latched_start;
  logic [CntW-1:0]     stored;
  run_status_t         state_now;
  logic [TsW-1:0]      min_seen, max_seen;
  logic [Q8W-1:0]      mean_now, dev_now;

  profile_t pending_profiles[$];
  int       mismatches = 0;
  bit       gaps_on = 1'b1;
  int       quiet_cycles = 0;

  interval_profiler_with_statistics_core i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  function automatic logic [CntW-1:0] usable_capacity();
    return (capacity_reg > MaxIntervals) ? CntW'(MaxIntervals) : capacity_reg;
  endfunction

  function automatic void compute_statistics();
    logic [CntW-1:0] n;
    logic [TsW-1:0]  total;
    logic [63:0]     scaled, diff, avg;
    logic [127:0]    acc, variance, trial, root;
    n = (stored < usable_capacity()) ? stored : usable_capacity();
    if (state_now != ST_STOPPED && state_now != ST_FULL) begin
      state_now = ST_ERROR;
      return;
    end
    if (n == 0) return;
    total = '0;
    for (int i = 0; i < n; i++) begin
      if (intervals[i] < min_seen) min_seen = intervals[i];
      if (intervals[i] > max_seen) max_seen = intervals[i];
      total += intervals[i];
    end
    avg = ({32'd0, total} << 8) / n;
    mean_now = avg[Q8W-1:0];
    acc = '0;
    for (int i = 0; i < n; i++) begin
      scaled = {24'd0, intervals[i], 8'd0};
      diff = (scaled >= avg) ? scaled - avg : avg - scaled;
      acc += 128'(diff) * 128'(diff);
    end
    variance = acc / n;
    root = '0;
    for (int b = 40; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= variance) root = trial;
    end
    dev_now = root[Q8W-1:0];
  endfunction

  function automatic profile_t apply_event(logic [1:0] op, logic [TsW-1:0] ts);
    profile_t p;
    if (op == OpStart) begin
      if (stored < usable_capacity()) begin
        latched_start = ts;
        state_now = ST_RUNNING;
      end else begin
        state_now = ST_FULL;
      end
    end else if (op == OpStop) begin
      if (stored < usable_capacity()) begin
        intervals[stored] = ts - latched_start;
        stored++;
        state_now = ST_STOPPED;
        if (stored == usable_capacity()) begin
          state_now = ST_FULL;
          if (mode_reg == ModeAuto1 || mode_reg == ModeAuto2) compute_statistics();
        end
      end else begin
        state_now = ST_FULL;
      end
    end else if (op == OpCalc) begin
      compute_statistics();
    end
    p.status = state_now;
    p.count = stored;
    p.min_time = min_seen;
    p.max_time = max_seen;
    p.mean_q8 = mean_now;
    p.stddev_q8 = dev_now;
    return p;
  endfunction

  task automatic send_word(logic [1:0] op, logic [TsW-1:0] ts);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = ts;
    do @(posedge clk); while (!s_tready);
    pending_profiles.push_back(apply_event(op, ts));
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (pending_profiles.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegCapacity) capacity_reg = value;
    else mode_reg = value[1:0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_special_cases();
    send_word(OpCalc, 32'h0000_1234);
    send_word(OpIgnored, 32'hFFFF_FFFF);
    write_register(RegCapacity, 7'd0);
    send_word(OpStart, 32'h0000_0100);
    send_word(OpStop, 32'h0000_0200);
    send_word(OpCalc, 32'h0);
    write_register(RegCapacity, 7'd64);
    write_register(RegStatsMode, 7'd0);
    send_word(OpStop, 32'h0000_0005);
    send_word(OpStart, 32'hFFFF_FFF0);
    send_word(OpStart, 32'hFFFF_FFFF);
    send_word(OpStop, 32'h0000_0010);
    send_word(OpStart, 32'h0);
    send_word(OpStop, 32'hFFFF_FFFF);
    send_word(OpCalc, 32'h0);
    send_word(OpIgnored, 32'h0);
    send_word(OpCalc, 32'hAAAA_5555);
  endtask

  task automatic test_auto_fill();
    write_register(RegCapacity, 7'd6);
    write_register(RegStatsMode, 7'd1);
    for (int k = 0; k < 3; k++) begin
      send_word(OpStart, 32'h1000 * k);
      send_word(OpStop, 32'h1000 * k + 32'd77 * k);
    end
    send_word(OpStart, 32'h5);
    send_word(OpStop, 32'h9);
    send_word(OpCalc, 32'h0);
  endtask

  task automatic test_random_phase(int capacity, int mode, int words);
    int sent;
    logic [TsW-1:0] t0;
    write_register(RegCapacity, CapW'(capacity));
    write_register(RegStatsMode, CapW'(mode));
    sent = 0;
    while (sent < words) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          send_word(OpCalc, $urandom);
          sent++;
        end
        3, 4: begin
          send_word(2'($urandom_range(0, 3)), $urandom);
          sent++;
        end
        default: begin
          t0 = $urandom;
          send_word(OpStart, t0);
          if ($urandom_range(0, 4) == 0) t0 = $urandom;
          else t0 = t0 + $urandom_range(0, 5000);
          send_word(OpStop, t0);
          sent += 2;
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    profile_t want;
    if (m_tvalid && m_tready) begin
      if (pending_profiles.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, m_tdata);
        mismatches++;
      end else begin
        want = pending_profiles.pop_front();
        if (m_tdata[2:0] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $realtime, want.status, m_tdata[2:0]);
          mismatches++;
        end
        if (m_tdata[9:3] !== want.count) begin
          $display("%0t: count expected %0d got %0d", $realtime, want.count, m_tdata[9:3]);
          mismatches++;
        end
        if (m_tdata[41:10] !== want.min_time) begin
          $display("%0t: min expected %h got %h", $realtime, want.min_time, m_tdata[41:10]);
          mismatches++;
        end
        if (m_tdata[73:42] !== want.max_time) begin
          $display("%0t: max expected %h got %h", $realtime, want.max_time, m_tdata[73:42]);
          mismatches++;
        end
        if (m_tdata[113:74] !== want.mean_q8) begin
          $display("%0t: mean expected %h got %h", $realtime, want.mean_q8, m_tdata[113:74]);
          mismatches++;
        end
        if (m_tdata[153:114] !== want.stddev_q8) begin
          $display("%0t: stddev expected %h got %h", $realtime, want.stddev_q8,
                   m_tdata[153:114]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    capacity_reg = 7'd64;
    mode_reg = 2'd0;
    latched_start = '0;
    stored = '0;
    state_now = ST_IDLE;
    min_seen = '1;
    max_seen = '0;
    mean_now = '0;
    dev_now = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_special_cases();
    test_auto_fill();
    test_random_phase(12, 2, 130);
    test_random_phase(20, 3, 130);
    test_random_phase(8, 0, 100);
    test_random_phase(33, 1, 130);
    test_random_phase(1, 2, 60);
    test_random_phase(50, 0, 130);
    test_random_phase(127, 1, 150);
    gaps_on = 1'b0;
    test_random_phase(64, 3, 150);
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
